// File: hdl/dms_pkg.sv
// shared types, constants and rate table of the delta modulation sample channel
`default_nettype none

package dms_pkg;

    localparam int FUNC_W      = 3;
    localparam int VALUE_W     = 7;
    localparam int BYTE_W      = 8;
    localparam int LEVEL_W     = 7;
    localparam int ADDR_W      = 16;
    localparam int COUNT_W     = 12;
    localparam int DIV_W       = 9;
    localparam int RATE_W      = 4;
    localparam int BITCNT_W    = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [FUNC_W-1:0] FUNC_TICK      = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_CHAN_EN   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_IRQ_EN    = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_IRQ_CLR   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_LEVEL = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] CFG_RATE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOOP   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_START  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH = 2'd3;

    localparam logic [ADDR_W-1:0]   ADDR_LAST  = 16'hFFFF;
    localparam logic [ADDR_W-1:0]   ADDR_WRAP  = 16'h8000;
    localparam logic [LEVEL_W-1:0]  LEVEL_STEP = 7'd2;
    localparam logic [LEVEL_W-1:0]  LEVEL_TOP  = 7'd125;
    localparam logic [BITCNT_W-1:0] BIT_RELOAD = 3'd7;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_TICK,
        OP_CHAN_EN,
        OP_IRQ_EN,
        OP_IRQ_CLR,
        OP_LOAD_LEVEL
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [VALUE_W-1:0] value;
        logic [BYTE_W-1:0]  mem;
    } cmd_t;

    function automatic logic [DIV_W-1:0] rate_period(input logic [RATE_W-1:0] idx);
        logic [DIV_W-1:0] p;
        case (idx)
            4'd0:    p = 9'd428;
            4'd1:    p = 9'd380;
            4'd2:    p = 9'd340;
            4'd3:    p = 9'd320;
            4'd4:    p = 9'd286;
            4'd5:    p = 9'd254;
            4'd6:    p = 9'd226;
            4'd7:    p = 9'd214;
            4'd8:    p = 9'd190;
            4'd9:    p = 9'd160;
            4'd10:   p = 9'd142;
            4'd11:   p = 9'd128;
            4'd12:   p = 9'd106;
            4'd13:   p = 9'd84;
            4'd14:   p = 9'd72;
            default: p = 9'd54;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// File: hdl/delta_modulation_sample_channel.sv
// top level of the delta modulation sample channel
`default_nettype none

// One-bit delta modulation audio voice. Each request carries a command (tick, channel
// enable, interrupt enable, interrupt clear or level load) and returns exactly one
// result with the level, interrupt line, next fetch address and the more-samples flag
// after that command. One request is taken every clock cycle when the result side
// keeps up; a request passes the front end register, the command queue and the
// result register in that order before its result appears on the m_ side.
// Configuration writes are taken at any time with cfg_ready held high and must
// be issued only while no request is in flight.

module delta_modulation_sample_channel #(
    parameter int QUEUE_DEPTH = dms_pkg::QUEUE_DEPTH
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [dms_pkg::FUNC_W-1:0]      s_func,
    input  wire logic [dms_pkg::VALUE_W-1:0]     s_value,
    input  wire logic [dms_pkg::BYTE_W-1:0]      s_memory_byte,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [dms_pkg::LEVEL_W-1:0]          m_level,
    output logic                                 m_irq,
    output logic [dms_pkg::ADDR_W-1:0]           m_fetch_address,
    output logic                                 m_more_samples,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [dms_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [dms_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic          front_valid;
    logic          front_ready;
    dms_pkg::cmd_t front_cmd;
    logic          queue_valid;
    logic          queue_ready;
    dms_pkg::cmd_t queue_cmd;

    assign cfg_ready = 1'b1;

    dms_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_value       (s_value),
        .s_memory_byte (s_memory_byte),
        .cmd_valid     (front_valid),
        .cmd_ready     (front_ready),
        .cmd           (front_cmd)
    );

    dms_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_cmd   (queue_cmd)
    );

    dms_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd_valid       (queue_valid),
        .cmd_ready       (queue_ready),
        .cmd             (queue_cmd),
        .cfg_wr          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_level         (m_level),
        .m_irq           (m_irq),
        .m_fetch_address (m_fetch_address),
        .m_more_samples  (m_more_samples)
    );

endmodule

`default_nettype wire

// File: hdl/dms_front.sv
// front end: accepts requests and decodes them into commands
`default_nettype none

module dms_front (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [dms_pkg::FUNC_W-1:0] s_func,
    input  wire logic [dms_pkg::VALUE_W-1:0] s_value,
    input  wire logic [dms_pkg::BYTE_W-1:0] s_memory_byte,
    output logic                            cmd_valid,
    input  wire logic                       cmd_ready,
    output dms_pkg::cmd_t                   cmd
);

    logic          valid_reg;
    logic          valid_next;
    dms_pkg::cmd_t cmd_reg;
    dms_pkg::op_t  op_dec;

    always_comb begin
        case (s_func)
            dms_pkg::FUNC_TICK:       op_dec = dms_pkg::OP_TICK;
            dms_pkg::FUNC_CHAN_EN:    op_dec = dms_pkg::OP_CHAN_EN;
            dms_pkg::FUNC_IRQ_EN:     op_dec = dms_pkg::OP_IRQ_EN;
            dms_pkg::FUNC_IRQ_CLR:    op_dec = dms_pkg::OP_IRQ_CLR;
            dms_pkg::FUNC_LOAD_LEVEL: op_dec = dms_pkg::OP_LOAD_LEVEL;
            default:                  op_dec = dms_pkg::OP_NOP;
        endcase
    end

    assign s_ready = !valid_reg || cmd_ready;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_valid && s_ready) begin
            cmd_reg.op    <= op_dec;
            cmd_reg.value <= s_value;
            cmd_reg.mem   <= s_memory_byte;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

`default_nettype wire

// File: hdl/dms_queue.sv
// command queue between front end and back end
`default_nettype none

module dms_queue #(
    parameter int DEPTH = dms_pkg::QUEUE_DEPTH
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire dms_pkg::cmd_t in_cmd,
    output logic               out_valid,
    input  wire logic          out_ready,
    output dms_pkg::cmd_t      out_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dms_pkg::cmd_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

// File: hdl/dms_back.sv
// back end: channel state, divider, bit shifter, level update and result register
`default_nettype none

module dms_back (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cmd_valid,
    output logic                                 cmd_ready,
    input  wire dms_pkg::cmd_t                   cmd,
    input  wire logic                            cfg_wr,
    input  wire logic [dms_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [dms_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [dms_pkg::LEVEL_W-1:0]          m_level,
    output logic                                 m_irq,
    output logic [dms_pkg::ADDR_W-1:0]           m_fetch_address,
    output logic                                 m_more_samples
);

    localparam int LW = dms_pkg::LEVEL_W;
    localparam int AW = dms_pkg::ADDR_W;
    localparam int CW = dms_pkg::COUNT_W;
    localparam int DW = dms_pkg::DIV_W;
    localparam int BW = dms_pkg::BITCNT_W;
    localparam int SW = dms_pkg::BYTE_W;
    localparam int RW = dms_pkg::RATE_W;

    // configuration
    logic [RW-1:0] rate_reg;
    logic          loop_reg;
    logic [AW-1:0] start_reg;
    logic [CW-1:0] length_reg;

    // channel state
    logic [LW-1:0] level_reg,     level_next;
    logic          chan_en_reg,   chan_en_next;
    logic          irq_en_reg,    irq_en_next;
    logic          irq_flag_reg,  irq_flag_next;
    logic [CW-1:0] bytes_reg,     bytes_next;
    logic [AW-1:0] addr_reg,      addr_next;
    logic [SW-1:0] shifter_reg,   shifter_next;
    logic [BW-1:0] bits_reg,      bits_next;
    logic          silenced_reg,  silenced_next;
    logic [DW-1:0] div_reg,       div_next;

    // result register
    logic          out_valid_reg, out_valid_next;
    logic [LW-1:0] out_level_reg;
    logic          out_irq_reg;
    logic [AW-1:0] out_addr_reg;
    logic          out_more_reg;

    logic          exec;
    logic [SW-1:0] shift_src;
    logic [AW-1:0] addr_base;
    logic          pop_bit;

    assign cmd_ready = !out_valid_reg || m_ready;
    assign exec      = cmd_valid && cmd_ready;

    always_comb begin
        level_next    = level_reg;
        chan_en_next  = chan_en_reg;
        irq_en_next   = irq_en_reg;
        irq_flag_next = irq_flag_reg;
        bytes_next    = bytes_reg;
        addr_next     = addr_reg;
        shifter_next  = shifter_reg;
        bits_next     = bits_reg;
        silenced_next = silenced_reg;
        div_next      = div_reg;
        shift_src     = shifter_reg;
        addr_base     = (bytes_reg == '0) ? start_reg : addr_reg;
        pop_bit       = 1'b0;

        if (exec) begin
            case (cmd.op)
                dms_pkg::OP_TICK: begin
                    if (chan_en_reg) begin
                        if (div_reg > DW'(1)) begin
                            div_next = div_reg - DW'(1);
                        end else begin
                            div_next = dms_pkg::rate_period(rate_reg);
                            if (bits_reg == '0) begin
                                bits_next = dms_pkg::BIT_RELOAD;
                                if (bytes_reg == '0 && !loop_reg) begin
                                    silenced_next = 1'b1;
                                    if (irq_en_reg) begin
                                        irq_flag_next = 1'b1;
                                    end
                                end else begin
                                    silenced_next = 1'b0;
                                    shift_src     = cmd.mem;
                                    bytes_next    = (bytes_reg == '0) ? length_reg
                                                                      : bytes_reg - CW'(1);
                                    addr_next     = (addr_base == dms_pkg::ADDR_LAST)
                                                    ? dms_pkg::ADDR_WRAP
                                                    : addr_base + AW'(1);
                                end
                            end else begin
                                bits_next = bits_reg - BW'(1);
                            end
                            pop_bit      = shift_src[0];
                            shifter_next = shift_src >> 1;
                            if (!silenced_next) begin
                                if (pop_bit && level_reg <= dms_pkg::LEVEL_TOP) begin
                                    level_next = level_reg + dms_pkg::LEVEL_STEP;
                                end else if (!pop_bit && level_reg >= dms_pkg::LEVEL_STEP) begin
                                    level_next = level_reg - dms_pkg::LEVEL_STEP;
                                end
                            end
                        end
                    end
                end
                dms_pkg::OP_CHAN_EN: begin
                    chan_en_next = cmd.value[0];
                    if (!cmd.value[0]) begin
                        bytes_next = '0;
                    end else if (bytes_reg == '0) begin
                        addr_next  = start_reg;
                        bytes_next = length_reg;
                    end
                end
                dms_pkg::OP_IRQ_EN: begin
                    irq_en_next = cmd.value[0];
                    if (!cmd.value[0]) begin
                        irq_flag_next = 1'b0;
                    end
                end
                dms_pkg::OP_IRQ_CLR: begin
                    irq_flag_next = 1'b0;
                end
                dms_pkg::OP_LOAD_LEVEL: begin
                    level_next = cmd.value;
                end
                default: begin
                end
            endcase
        end

        // rate write reloads the divider
        if (cfg_wr && cfg_index == dms_pkg::CFG_RATE) begin
            div_next = dms_pkg::rate_period(cfg_data[RW-1:0]);
        end

        out_valid_next = out_valid_reg;
        if (exec) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg      <= '0;
            loop_reg      <= 1'b0;
            start_reg     <= '0;
            length_reg    <= '0;
            level_reg     <= '0;
            chan_en_reg   <= 1'b0;
            irq_en_reg    <= 1'b0;
            irq_flag_reg  <= 1'b0;
            bytes_reg     <= '0;
            addr_reg      <= '0;
            shifter_reg   <= '0;
            bits_reg      <= '0;
            silenced_reg  <= 1'b0;
            div_reg       <= dms_pkg::rate_period('0);
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (cfg_index)
                    dms_pkg::CFG_RATE:   rate_reg   <= cfg_data[RW-1:0];
                    dms_pkg::CFG_LOOP:   loop_reg   <= cfg_data[0];
                    dms_pkg::CFG_START:  start_reg  <= cfg_data[AW-1:0];
                    dms_pkg::CFG_LENGTH: length_reg <= cfg_data[CW-1:0];
                    default: begin
                    end
                endcase
            end
            level_reg     <= level_next;
            chan_en_reg   <= chan_en_next;
            irq_en_reg    <= irq_en_next;
            irq_flag_reg  <= irq_flag_next;
            bytes_reg     <= bytes_next;
            addr_reg      <= addr_next;
            shifter_reg   <= shifter_next;
            bits_reg      <= bits_next;
            silenced_reg  <= silenced_next;
            div_reg       <= div_next;
            out_valid_reg <= out_valid_next;
        end
        if (exec) begin
            out_level_reg <= level_next;
            out_irq_reg   <= irq_flag_next;
            out_addr_reg  <= addr_next;
            out_more_reg  <= bytes_next != '0;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_level         = out_level_reg;
    assign m_irq           = out_irq_reg;
    assign m_fetch_address = out_addr_reg;
    assign m_more_samples  = out_more_reg;

    // divider reloads before reaching zero
    assert property (@(posedge aclk) disable iff (!aresetn) div_reg != '0)
        else $error("divider count reached zero");

    // a disabled channel holds no pending bytes
    assert property (@(posedge aclk) disable iff (!aresetn) (bytes_reg != '0) |-> chan_en_reg)
        else $error("bytes pending while channel disabled");

    // interrupt flag only stands while interrupts are enabled
    assert property (@(posedge aclk) disable iff (!aresetn) irq_flag_reg |-> irq_en_reg)
        else $error("interrupt flag set with interrupts disabled");

    // divider moves only on an enabled tick or a rate write
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$past(cfg_wr) && !$stable(div_reg))
        |-> ($past(chan_en_reg) && $past(exec)))
        else $error("divider changed without an enabled tick");

endmodule

`default_nettype wire

// File: verif/dms_checker.sv
// checker of the delta modulation sample channel: tracks the channel state and compares every result
`default_nettype none

module dms_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    input  wire logic                            s_ready,
    input  wire logic [dms_pkg::FUNC_W-1:0]      s_func,
    input  wire logic [dms_pkg::VALUE_W-1:0]     s_value,
    input  wire logic [dms_pkg::BYTE_W-1:0]      s_memory_byte,
    input  wire logic                            m_valid,
    input  wire logic                            m_ready,
    input  wire logic [dms_pkg::LEVEL_W-1:0]     m_level,
    input  wire logic                            m_irq,
    input  wire logic [dms_pkg::ADDR_W-1:0]      m_fetch_address,
    input  wire logic                            m_more_samples,
    input  wire logic                            cfg_valid,
    input  wire logic                            cfg_ready,
    input  wire logic [dms_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [dms_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int unsigned                          mismatches,
    output int unsigned                          outstanding,
    output int unsigned                          checked,
    output int unsigned                          fires,
    output int unsigned                          fetches
);

    localparam int DW = dms_pkg::DIV_W;

    // divider periods, index 0 in the low bits
    localparam logic [16*DW-1:0] PERIOD_TABLE = {
        9'd54,  9'd72,  9'd84,  9'd106, 9'd128, 9'd142, 9'd160, 9'd190,
        9'd214, 9'd226, 9'd254, 9'd286, 9'd320, 9'd340, 9'd380, 9'd428
    };

    typedef struct packed {
        logic [dms_pkg::LEVEL_W-1:0] level;
        logic                        irq;
        logic [dms_pkg::ADDR_W-1:0]  addr;
        logic                        more;
    } channel_out_t;

    channel_out_t channel_outputs_due[$];

    logic [dms_pkg::RATE_W-1:0]   rate_sel;
    logic                         loop_on;
    logic [dms_pkg::ADDR_W-1:0]   start_addr;
    logic [dms_pkg::COUNT_W-1:0]  sample_len;
    logic [dms_pkg::LEVEL_W-1:0]  out_level;
    logic                         chan_on;
    logic                         irq_on;
    logic                         irq_flag;
    logic [dms_pkg::COUNT_W-1:0]  bytes_to_go;
    logic [dms_pkg::ADDR_W-1:0]   next_addr;
    logic [dms_pkg::BYTE_W-1:0]   sample_bits;
    logic [dms_pkg::BITCNT_W-1:0] bit_count;
    logic                         muted;
    logic [DW-1:0]                divider;

    function automatic logic [DW-1:0] period_of(input logic [dms_pkg::RATE_W-1:0] sel);
        return PERIOD_TABLE[sel*DW +: DW];
    endfunction

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
        end
    endfunction

    task automatic clock_divider(input logic [dms_pkg::BYTE_W-1:0] mem);
        logic popped;
        logic loaded;
        if (divider > 1) begin
            divider = divider - 1'b1;
        end else begin
            divider = period_of(rate_sel);
            fires++;
            if (bit_count == 0) begin
                bit_count = dms_pkg::BIT_RELOAD;
                loaded = 1'b1;
                if (bytes_to_go != 0) begin
                    bytes_to_go = bytes_to_go - 1'b1;
                end else if (loop_on) begin
                    next_addr = start_addr;
                    bytes_to_go = sample_len;
                end else begin
                    loaded = 1'b0;
                    if (irq_on)
                        irq_flag = 1'b1;
                end
                if (loaded) begin
                    sample_bits = mem;
                    next_addr = (next_addr == dms_pkg::ADDR_LAST) ? dms_pkg::ADDR_WRAP
                                                                  : next_addr + 1'b1;
                    fetches++;
                end
                muted = !loaded;
            end else begin
                bit_count = bit_count - 1'b1;
            end
            popped = sample_bits[0];
            sample_bits = sample_bits >> 1;
            if (!muted) begin
                if (popped && out_level <= dms_pkg::LEVEL_TOP)
                    out_level = out_level + dms_pkg::LEVEL_STEP;
                else if (!popped && out_level >= dms_pkg::LEVEL_STEP)
                    out_level = out_level - dms_pkg::LEVEL_STEP;
            end
        end
    endtask

    task automatic apply_request(input logic [dms_pkg::FUNC_W-1:0] func,
                                 input logic [dms_pkg::VALUE_W-1:0] value,
                                 input logic [dms_pkg::BYTE_W-1:0] mem,
                                 output channel_out_t res);
        case (func)
            dms_pkg::FUNC_TICK: begin
                if (chan_on)
                    clock_divider(mem);
            end
            dms_pkg::FUNC_CHAN_EN: begin
                chan_on = value[0];
                if (!chan_on) begin
                    bytes_to_go = '0;
                end else if (bytes_to_go == 0) begin
                    next_addr = start_addr;
                    bytes_to_go = sample_len;
                end
            end
            dms_pkg::FUNC_IRQ_EN: begin
                irq_on = value[0];
                if (!irq_on)
                    irq_flag = 1'b0;
            end
            dms_pkg::FUNC_IRQ_CLR: begin
                irq_flag = 1'b0;
            end
            dms_pkg::FUNC_LOAD_LEVEL: begin
                out_level = value;
            end
            default: begin
            end
        endcase
        res.level = out_level;
        res.irq   = irq_flag;
        res.addr  = next_addr;
        res.more  = (bytes_to_go != 0);
    endtask

    always @(posedge aclk) begin
        channel_out_t want;
        if (!aresetn) begin
            rate_sel    = '0;
            loop_on     = 1'b0;
            start_addr  = '0;
            sample_len  = '0;
            out_level   = '0;
            chan_on     = 1'b0;
            irq_on      = 1'b0;
            irq_flag    = 1'b0;
            bytes_to_go = '0;
            next_addr   = '0;
            sample_bits = '0;
            bit_count   = '0;
            muted       = 1'b0;
            divider     = period_of('0);
            channel_outputs_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    dms_pkg::CFG_RATE: begin
                        rate_sel = cfg_data[dms_pkg::RATE_W-1:0];
                        divider = period_of(rate_sel);
                    end
                    dms_pkg::CFG_LOOP:   loop_on = cfg_data[0];
                    dms_pkg::CFG_START:  start_addr = cfg_data;
                    dms_pkg::CFG_LENGTH: sample_len = cfg_data[dms_pkg::COUNT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (m_valid && m_ready) begin
                if (channel_outputs_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result level 0x%0h irq %0b addr 0x%0h more %0b",
                             $time, m_level, m_irq, m_fetch_address, m_more_samples);
                end else begin
                    want = channel_outputs_due.pop_front();
                    checked++;
                    compare_field("level", 16'(want.level), 16'(m_level));
                    compare_field("irq", 16'(want.irq), 16'(m_irq));
                    compare_field("fetch_address", want.addr, m_fetch_address);
                    compare_field("more_samples", 16'(want.more), 16'(m_more_samples));
                end
            end
            if (s_valid && s_ready) begin
                apply_request(s_func, s_value, s_memory_byte, want);
                channel_outputs_due.push_back(want);
            end
        end
        outstanding = channel_outputs_due.size();
    end

endmodule

`default_nettype wire

// File: verif/tb.sv
// testbench top of the delta modulation sample channel: stimulus, configuration and verdict
`default_nettype none

module tb;

    localparam int TARGET_ITEMS = 1050;
    localparam int CALM_ITEMS   = 150;
    localparam int FIRST_PHASE  = 480;
    localparam int CLK_HALF     = 10;
    localparam int RUN_LIMIT    = 4_000_000;

    localparam logic [dms_pkg::FUNC_W-1:0] FUNC_SPARE_LO  = 3'd5;
    localparam logic [dms_pkg::FUNC_W-1:0] FUNC_SPARE_MID = 3'd6;
    localparam logic [dms_pkg::FUNC_W-1:0] FUNC_SPARE_HI  = 3'd7;

    logic                            aclk          = 1'b0;
    logic                            aresetn       = 1'b0;
    logic                            s_valid       = 1'b0;
    logic [dms_pkg::FUNC_W-1:0]      s_func        = '0;
    logic [dms_pkg::VALUE_W-1:0]     s_value       = '0;
    logic [dms_pkg::BYTE_W-1:0]      s_memory_byte = '0;
    logic                            m_ready       = 1'b0;
    logic                            cfg_valid     = 1'b0;
    logic [dms_pkg::CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [dms_pkg::CFG_DATA_W-1:0]  cfg_data      = '0;

    logic                        s_ready;
    logic                        m_valid;
    logic [dms_pkg::LEVEL_W-1:0] m_level;
    logic                        m_irq;
    logic [dms_pkg::ADDR_W-1:0]  m_fetch_address;
    logic                        m_more_samples;
    logic                        cfg_ready;

    bit          bursts_on  = 1'b0;
    int          stall_left = 0;
    int unsigned items_sent = 0;
    int unsigned reg_writes = 0;
    int unsigned mismatches, outstanding, checked, fires, fetches;

    always begin
        #(CLK_HALF) aclk = 1'b1;
        #(CLK_HALF) aclk = 1'b0;
    end

    delta_modulation_sample_channel dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_value         (s_value),
        .s_memory_byte   (s_memory_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_level         (m_level),
        .m_irq           (m_irq),
        .m_fetch_address (m_fetch_address),
        .m_more_samples  (m_more_samples),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    dms_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_value         (s_value),
        .s_memory_byte   (s_memory_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_level         (m_level),
        .m_irq           (m_irq),
        .m_fetch_address (m_fetch_address),
        .m_more_samples  (m_more_samples),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .checked         (checked),
        .fires           (fires),
        .fetches         (fetches)
    );

    // result side back-pressure in bursts of random length
    always @(negedge aclk) begin
        if (bursts_on && stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (bursts_on && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            stall_left <= $urandom_range(0, 14);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_item(input logic [dms_pkg::FUNC_W-1:0] func,
                             input logic [dms_pkg::VALUE_W-1:0] value,
                             input logic [dms_pkg::BYTE_W-1:0] mem);
        if (bursts_on && $urandom_range(0, 6) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_func        <= func;
        s_value       <= value;
        s_memory_byte <= mem;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic write_reg(input logic [dms_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [dms_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        reg_writes++;
    endtask

    // unused upper bits of the data carry noise
    task automatic program_regs(input logic [3:0] rate, input logic loop_bit,
                                input logic [15:0] start, input logic [11:0] len);
        logic [15:0] noise;
        noise = 16'($urandom);
        write_reg(dms_pkg::CFG_RATE, {noise[15:4], rate});
        write_reg(dms_pkg::CFG_LOOP, {noise[15:1], loop_bit});
        write_reg(dms_pkg::CFG_START, start);
        write_reg(dms_pkg::CFG_LENGTH, {noise[15:12], len});
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic send_random_item();
        int unsigned roll;
        logic [dms_pkg::VALUE_W-1:0] v;
        logic [dms_pkg::BYTE_W-1:0] mem;
        roll = $urandom_range(0, 99);
        v    = 7'($urandom);
        mem  = 8'($urandom);
        if (roll < 90) begin
            send_item(dms_pkg::FUNC_TICK, v, mem);
        end else if (roll < 92) begin
            v[0] = ($urandom_range(0, 3) != 0);
            send_item(dms_pkg::FUNC_CHAN_EN, v, mem);
        end else if (roll < 94) begin
            send_item(dms_pkg::FUNC_IRQ_EN, v, mem);
        end else if (roll < 95) begin
            send_item(dms_pkg::FUNC_IRQ_CLR, v, mem);
        end else if (roll < 98) begin
            if ($urandom_range(0, 1))
                v = $urandom_range(0, 1) ? 7'($urandom_range(125, 127)) : 7'($urandom_range(0, 2));
            send_item(dms_pkg::FUNC_LOAD_LEVEL, v, mem);
        end else begin
            send_item(3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI)), v, mem);
        end
    endtask

    task automatic run_phase(input int unsigned count);
        repeat (count) send_random_item();
        settle();
    endtask

    initial begin
        logic [3:0]  rate;
        logic [15:0] start;
        logic [11:0] len;
        int unsigned room;
        int unsigned chunk;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // slowest rate, longest sample at address zero
        program_regs(4'd0, 1'b0, 16'h0000, 12'hFFF);
        send_item(dms_pkg::FUNC_TICK, 7'h7F, 8'hFF);
        send_item(dms_pkg::FUNC_LOAD_LEVEL, 7'h7F, 8'h00);
        send_item(dms_pkg::FUNC_LOAD_LEVEL, 7'h00, 8'hFF);
        send_item(dms_pkg::FUNC_IRQ_EN, 7'h01, 8'h00);
        send_item(dms_pkg::FUNC_IRQ_CLR, 7'h7F, 8'hFF);
        send_item(dms_pkg::FUNC_CHAN_EN, 7'h7E, 8'h00);
        send_item(dms_pkg::FUNC_CHAN_EN, 7'h01, 8'hFF);
        send_item(dms_pkg::FUNC_TICK, 7'h00, 8'h00);
        send_item(dms_pkg::FUNC_CHAN_EN, 7'h00, 8'hFF);
        send_item(dms_pkg::FUNC_IRQ_EN, 7'h7E, 8'h00);
        send_item(FUNC_SPARE_LO, 7'h7F, 8'hAA);
        send_item(FUNC_SPARE_MID, 7'h2A, 8'h55);
        send_item(FUNC_SPARE_HI, 7'h55, 8'hFF);
        send_item(dms_pkg::FUNC_LOAD_LEVEL, 7'd126, 8'h00);
        send_item(dms_pkg::FUNC_LOAD_LEVEL, 7'd1, 8'hFF);
        settle();

        // fastest rate, looping empty sample at the top of memory: first fetch wraps
        bursts_on <= 1'b1;
        program_regs(4'd15, 1'b1, 16'hFFFF, 12'd0);
        send_item(dms_pkg::FUNC_IRQ_EN, 7'h01, 8'($urandom));
        send_item(dms_pkg::FUNC_LOAD_LEVEL, 7'($urandom), 8'($urandom));
        send_item(dms_pkg::FUNC_CHAN_EN, 7'h01, 8'($urandom));
        run_phase(FIRST_PHASE);

        while (items_sent < TARGET_ITEMS - CALM_ITEMS) begin
            bursts_on <= ($urandom_range(0, 3) != 0);
            rate = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(13, 15)) : 4'($urandom);
            case ($urandom_range(0, 5))
                0, 1:    start = 16'($urandom_range(16'hFFF8, 16'hFFFF));
                2:       start = 16'h0000;
                default: start = 16'($urandom);
            endcase
            case ($urandom_range(0, 7))
                0, 1:    len = 12'd0;
                2, 3:    len = 12'($urandom_range(1, 3));
                4:       len = 12'hFFF;
                default: len = 12'($urandom);
            endcase
            program_regs(rate, 1'($urandom), start, len);
            send_item(dms_pkg::FUNC_CHAN_EN, {6'($urandom), 1'b1}, 8'($urandom));
            if ($urandom_range(0, 1))
                send_item(dms_pkg::FUNC_IRQ_EN, 7'($urandom), 8'($urandom));
            room  = (items_sent < TARGET_ITEMS - CALM_ITEMS)
                    ? TARGET_ITEMS - CALM_ITEMS - items_sent : 1;
            chunk = $urandom_range(60, 160);
            run_phase((chunk > room) ? room : chunk);
        end

        bursts_on <= 1'b0;
        program_regs(4'd15, 1'($urandom), 16'($urandom), 12'($urandom_range(0, 2)));
        send_item(dms_pkg::FUNC_CHAN_EN, 7'h01, 8'($urandom));
        run_phase(CALM_ITEMS);

        $display("covered %0d requests and %0d register writes, %0d results checked",
                 items_sent, reg_writes, checked);
        $display("divider fired %0d times, %0d sample bytes fetched", fires, fetches);
        if (mismatches == 0)
            $display("delta_modulation_sample_channel: match");
        else
            $display("delta_modulation_sample_channel: mismatch");
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("timeout with %0d results outstanding", outstanding);
        $display("delta_modulation_sample_channel: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
